[hw/rtl/ssc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and byte classifiers for the scoped identifier scanner.
package ssc_pkg;

    // Byte offsets and output field widths
    localparam int POS_BITS  = 32;
    localparam int OUT_BITS  = 32;

    // Character events produced per input byte (two held bytes plus the new one)
    localparam int EVT_SLOTS = 3;

    // Front-to-back queue
    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    // Run counter and threshold register
    localparam int RUN_BITS = 4;
    localparam logic [RUN_BITS-1:0] RUN_MAX       = '1;
    localparam logic [RUN_BITS-1:0] MIN_RUN_RESET = RUN_BITS'(4);

    // Multi-byte letter encodings
    localparam logic [7:0] LEAD_C4  = 8'hC4;
    localparam logic [7:0] LEAD_C5  = 8'hC5;
    localparam logic [7:0] LEAD_E2  = 8'hE2;
    localparam logic [7:0] TRAIL_B0 = 8'hB0;
    localparam logic [7:0] TRAIL_B1 = 8'hB1;
    localparam logic [7:0] TRAIL_BF = 8'hBF;
    localparam logic [7:0] MID_84   = 8'h84;
    localparam logic [7:0] TRAIL_AA = 8'hAA;

    typedef logic [POS_BITS-1:0] t_pos;

    typedef enum logic [1:0] {
        CLS_LETTER,
        CLS_DIGIT,
        CLS_COLON,
        CLS_OTHER
    } t_cls;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RUN,
        PH_NAME,
        PH_COL1,
        PH_COL2
    } t_phase;

    // Lead bytes waiting for their continuation
    typedef enum logic [2:0] {
        HELD_NONE,
        HELD_C4,
        HELD_C5,
        HELD_E2,
        HELD_E284
    } t_held;

    typedef struct packed {
        logic vld;
        t_cls cls;
        t_pos pos;
    } t_evt;

    // One queue entry: the classified characters of one accepted beat
    typedef struct packed {
        t_evt [EVT_SLOTS-1:0] evt;
        logic                 last;
        t_pos                 end_pos;
    } t_item;

    typedef struct packed {
        t_phase              phase;
        logic [RUN_BITS-1:0] run_cnt;
        t_pos                cand;
        t_pos                name_end;
    } t_scan;

    typedef struct packed {
        t_scan scan;
        logic  rep;
        t_pos  rep_start;
        t_pos  rep_end;
    } t_feed;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Classify a single byte as ASCII
    function automatic t_cls classify(input logic [7:0] c);
        t_cls cls;
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
            cls = CLS_LETTER;
        end else if (c >= "0" && c <= "9") begin
            cls = CLS_DIGIT;
        end else if (c == ":") begin
            cls = CLS_COLON;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

    function automatic logic is_lead(input logic [7:0] c);
        return (c == LEAD_C4) || (c == LEAD_C5) || (c == LEAD_E2);
    endfunction

    // Clamp an offset to the output field width
    function automatic logic [OUT_BITS-1:0] sat_out(input t_pos v);
        logic [POS_BITS+OUT_BITS-1:0] wide;
        logic [POS_BITS+OUT_BITS-1:0] lim;
        wide = {{OUT_BITS{1'b0}}, v};
        lim  = {{POS_BITS{1'b0}}, {OUT_BITS{1'b1}}};
        if (wide > lim) begin
            return '1;
        end
        return wide[OUT_BITS-1:0];
    endfunction

endpackage

[hw/rtl/ssc_front.sv]
`timescale 1ns / 1ps
// Front end: holds UTF-8 lead bytes and turns each beat into character events.
module ssc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_byte_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_byte_last,
    output logic          o_byte_ready,
    input  logic          i_q_full,
    output logic          o_push,
    output ssc_pkg::t_item o_item
);

    ssc_pkg::t_held r_held;
    ssc_pkg::t_held n_held;
    ssc_pkg::t_pos  r_pos0;
    ssc_pkg::t_pos  n_pos0;
    ssc_pkg::t_pos  r_pos1;
    ssc_pkg::t_pos  n_pos1;
    ssc_pkg::t_pos  r_byte_pos;
    ssc_pkg::t_pos  n_byte_pos;
    ssc_pkg::t_pos  w_next_pos;
    logic           w_fresh;
    ssc_pkg::t_item w_item;

    function automatic ssc_pkg::t_evt mk_evt(input ssc_pkg::t_cls cls,
                                             input ssc_pkg::t_pos pos);
        ssc_pkg::t_evt e;
        e.vld = 1'b1;
        e.cls = cls;
        e.pos = pos;
        return e;
    endfunction

    function automatic ssc_pkg::t_held lead_kind(input logic [7:0] c);
        ssc_pkg::t_held h;
        case (c)
            ssc_pkg::LEAD_C4: h = ssc_pkg::HELD_C4;
            ssc_pkg::LEAD_C5: h = ssc_pkg::HELD_C5;
            ssc_pkg::LEAD_E2: h = ssc_pkg::HELD_E2;
            default:          h = ssc_pkg::HELD_NONE;
        endcase
        return h;
    endfunction

    assign o_byte_ready = !i_q_full;
    assign o_push       = i_byte_valid && !i_q_full;
    assign o_item       = w_item;

    // Saturating offset of the byte after this one
    assign w_next_pos = (r_byte_pos == '1) ? r_byte_pos : r_byte_pos + 1'b1;

    // Resolve held lead bytes against the new byte; the new byte's own event goes last
    always_comb begin
        w_item         = '0;
        w_item.last    = i_byte_last;
        w_item.end_pos = w_next_pos;
        w_fresh        = 1'b0;
        n_held         = ssc_pkg::HELD_NONE;
        n_pos0         = r_pos0;
        n_pos1         = r_pos1;
        case (r_held)
            ssc_pkg::HELD_C4: begin
                if (i_byte == ssc_pkg::TRAIL_B0 || i_byte == ssc_pkg::TRAIL_B1) begin
                    w_item.evt[0] = mk_evt(ssc_pkg::CLS_LETTER, r_pos0);
                end else begin
                    w_item.evt[0] = mk_evt(ssc_pkg::CLS_OTHER, r_pos0);
                    w_fresh       = 1'b1;
                end
            end
            ssc_pkg::HELD_C5: begin
                if (i_byte == ssc_pkg::TRAIL_BF) begin
                    w_item.evt[0] = mk_evt(ssc_pkg::CLS_LETTER, r_pos0);
                end else begin
                    w_item.evt[0] = mk_evt(ssc_pkg::CLS_OTHER, r_pos0);
                    w_fresh       = 1'b1;
                end
            end
            ssc_pkg::HELD_E2: begin
                if (i_byte == ssc_pkg::MID_84) begin
                    if (i_byte_last) begin
                        w_item.evt[0] = mk_evt(ssc_pkg::CLS_OTHER, r_pos0);
                        w_item.evt[1] = mk_evt(ssc_pkg::CLS_OTHER, r_byte_pos);
                    end else begin
                        n_held = ssc_pkg::HELD_E284;
                        n_pos1 = r_byte_pos;
                    end
                end else begin
                    w_item.evt[0] = mk_evt(ssc_pkg::CLS_OTHER, r_pos0);
                    w_fresh       = 1'b1;
                end
            end
            ssc_pkg::HELD_E284: begin
                if (i_byte == ssc_pkg::TRAIL_AA) begin
                    w_item.evt[0] = mk_evt(ssc_pkg::CLS_LETTER, r_pos0);
                end else begin
                    w_item.evt[0] = mk_evt(ssc_pkg::CLS_OTHER, r_pos0);
                    w_item.evt[1] = mk_evt(ssc_pkg::CLS_OTHER, r_pos1);
                    w_fresh       = 1'b1;
                end
            end
            default: begin
                w_fresh = 1'b1;
            end
        endcase

        // New byte starts from an empty window: hold a lead byte unless the text ends
        if (w_fresh) begin
            if (ssc_pkg::is_lead(i_byte) && !i_byte_last) begin
                n_held = lead_kind(i_byte);
                n_pos0 = r_byte_pos;
            end else begin
                w_item.evt[2] = mk_evt(ssc_pkg::classify(i_byte), r_byte_pos);
            end
        end

        n_byte_pos = i_byte_last ? '0 : w_next_pos;
    end

    // Advance the window on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= ssc_pkg::HELD_NONE;
            r_byte_pos <= '0;
        end else if (o_push) begin
            r_held     <= n_held;
            r_byte_pos <= n_byte_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_pos0 <= n_pos0;
            r_pos1 <= n_pos1;
        end
    end

endmodule

[hw/rtl/ssc_queue.sv]
`timescale 1ns / 1ps
// Short FIFO of classified beats between the front end and the scan back end.
module ssc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ssc_pkg::t_item      i_item,
    input  logic                i_pop,
    output ssc_pkg::t_item      o_item,
    output ssc_pkg::t_q_status  o_status
);

    ssc_pkg::t_item                  r_slot [ssc_pkg::QDEPTH];
    logic [ssc_pkg::QPTR_BITS-1:0]   r_wr_ptr;
    logic [ssc_pkg::QPTR_BITS-1:0]   r_rd_ptr;
    logic [ssc_pkg::QCNT_BITS-1:0]   r_count;

    function automatic logic [ssc_pkg::QPTR_BITS-1:0] ptr_inc(
        input logic [ssc_pkg::QPTR_BITS-1:0] p);
        if (p == ssc_pkg::QPTR_BITS'(ssc_pkg::QDEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign o_item         = r_slot[r_rd_ptr];
    assign o_status.full  = (r_count == ssc_pkg::QCNT_BITS'(ssc_pkg::QDEPTH));
    assign o_status.empty = (r_count == '0);

    // Track fill level and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

[hw/rtl/ssc_back.sv]
`timescale 1ns / 1ps
// Back end: runs the name state machine over character events and registers results.
module ssc_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [ssc_pkg::RUN_BITS-1:0]        i_min_run,
    input  logic                                i_item_valid,
    input  ssc_pkg::t_item                      i_item,
    output logic                                o_pop,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [ssc_pkg::OUT_BITS-1:0]        o_name_start,
    output logic [ssc_pkg::OUT_BITS-1:0]        o_name_length,
    output logic                                o_name_valid,
    output logic                                o_text_end
);

    ssc_pkg::t_scan                 r_scan;
    ssc_pkg::t_scan                 n_scan;
    ssc_pkg::t_scan                 w_stage [ssc_pkg::EVT_SLOTS+1];
    logic [ssc_pkg::EVT_SLOTS-1:0]  w_rep;
    ssc_pkg::t_pos                  w_rep_start [ssc_pkg::EVT_SLOTS];
    ssc_pkg::t_pos                  w_rep_end [ssc_pkg::EVT_SLOTS];
    logic                           w_hit;
    ssc_pkg::t_pos                  w_hit_start;
    ssc_pkg::t_pos                  w_hit_end;
    ssc_pkg::t_pos                  w_hit_len;
    logic                           w_emit;

    logic                           r_out_valid;
    logic [ssc_pkg::OUT_BITS-1:0]   r_out_start;
    logic [ssc_pkg::OUT_BITS-1:0]   r_out_len;
    logic                           r_out_name_valid;
    logic                           r_out_end;

    // One character through the scan state machine
    function automatic ssc_pkg::t_feed feed(input ssc_pkg::t_scan s,
                                            input ssc_pkg::t_evt e,
                                            input logic [ssc_pkg::RUN_BITS-1:0] min_run);
        ssc_pkg::t_feed f;
        logic           word;
        logic           letter;
        f.scan      = s;
        f.rep       = 1'b0;
        f.rep_start = s.cand;
        f.rep_end   = '0;
        letter      = (e.cls == ssc_pkg::CLS_LETTER);
        word        = letter || (e.cls == ssc_pkg::CLS_DIGIT);
        case (s.phase)
            ssc_pkg::PH_RUN: begin
                if (word) begin
                    if (s.run_cnt != ssc_pkg::RUN_MAX) begin
                        f.scan.run_cnt = s.run_cnt + 1'b1;
                    end
                    if (f.scan.run_cnt >= min_run) begin
                        f.scan.phase = ssc_pkg::PH_NAME;
                    end
                end else begin
                    f.scan.phase = ssc_pkg::PH_IDLE;
                end
            end
            ssc_pkg::PH_NAME: begin
                if (!word) begin
                    f.scan.name_end = e.pos;
                    if (e.cls == ssc_pkg::CLS_COLON) begin
                        f.scan.phase = ssc_pkg::PH_COL1;
                    end else begin
                        f.rep        = 1'b1;
                        f.rep_end    = e.pos;
                        f.scan.phase = ssc_pkg::PH_IDLE;
                    end
                end
            end
            ssc_pkg::PH_COL1: begin
                if (e.cls == ssc_pkg::CLS_COLON) begin
                    f.scan.phase = ssc_pkg::PH_COL2;
                end else begin
                    f.rep        = 1'b1;
                    f.rep_end    = s.name_end;
                    f.scan.phase = ssc_pkg::PH_IDLE;
                    if (letter) begin
                        f.scan.cand    = e.pos;
                        f.scan.run_cnt = ssc_pkg::RUN_BITS'(1);
                        f.scan.phase   = (min_run <= ssc_pkg::RUN_BITS'(1)) ?
                                         ssc_pkg::PH_NAME : ssc_pkg::PH_RUN;
                    end
                end
            end
            ssc_pkg::PH_COL2: begin
                if (word) begin
                    f.scan.phase = ssc_pkg::PH_NAME;
                end else begin
                    f.rep        = 1'b1;
                    f.rep_end    = s.name_end;
                    f.scan.phase = ssc_pkg::PH_IDLE;
                end
            end
            default: begin
                f.scan.phase = ssc_pkg::PH_IDLE;
                if (letter) begin
                    f.scan.cand    = e.pos;
                    f.scan.run_cnt = ssc_pkg::RUN_BITS'(1);
                    f.scan.phase   = (min_run <= ssc_pkg::RUN_BITS'(1)) ?
                                     ssc_pkg::PH_NAME : ssc_pkg::PH_RUN;
                end
            end
        endcase
        return f;
    endfunction

    // Take a beat whenever the result register is free or being drained
    assign o_pop = i_item_valid && (!r_out_valid || i_out_ready);

    // Next state: chain the events of the head beat in order
    always_comb begin
        ssc_pkg::t_feed f;
        f          = '0;
        w_stage[0] = r_scan;
        for (int k = 0; k < ssc_pkg::EVT_SLOTS; k++) begin
            if (i_item.evt[k].vld) begin
                f              = feed(w_stage[k], i_item.evt[k], i_min_run);
                w_stage[k+1]   = f.scan;
                w_rep[k]       = f.rep;
                w_rep_start[k] = f.rep_start;
                w_rep_end[k]   = f.rep_end;
            end else begin
                w_stage[k+1]   = w_stage[k];
                w_rep[k]       = 1'b0;
                w_rep_start[k] = '0;
                w_rep_end[k]   = '0;
            end
        end
        if (o_pop) begin
            n_scan = i_item.last ? ssc_pkg::t_scan'('0) : w_stage[ssc_pkg::EVT_SLOTS];
        end else begin
            n_scan = r_scan;
        end
    end

    // Outputs: keep the first name reported, then, if none was, close a pending one at end of text
    always_comb begin
        w_hit       = 1'b0;
        w_hit_start = '0;
        w_hit_end   = '0;
        for (int k = 0; k < ssc_pkg::EVT_SLOTS; k++) begin
            if (w_rep[k] && !w_hit) begin
                w_hit       = 1'b1;
                w_hit_start = w_rep_start[k];
                w_hit_end   = w_rep_end[k];
            end
        end
        if (i_item.last && !w_hit) begin
            case (w_stage[ssc_pkg::EVT_SLOTS].phase)
                ssc_pkg::PH_NAME: begin
                    w_hit       = 1'b1;
                    w_hit_start = w_stage[ssc_pkg::EVT_SLOTS].cand;
                    w_hit_end   = i_item.end_pos;
                end
                ssc_pkg::PH_COL1, ssc_pkg::PH_COL2: begin
                    w_hit       = 1'b1;
                    w_hit_start = w_stage[ssc_pkg::EVT_SLOTS].cand;
                    w_hit_end   = w_stage[ssc_pkg::EVT_SLOTS].name_end;
                end
                default: begin
                    w_hit = 1'b0;
                end
            endcase
        end
        w_hit_len = w_hit_end - w_hit_start;
        w_emit    = o_pop && (w_hit || i_item.last);
    end

    // Scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
        end
    end

    // Result register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_start      <= ssc_pkg::sat_out(w_hit_start);
            r_out_len        <= ssc_pkg::sat_out(w_hit_len);
            r_out_name_valid <= w_hit;
            r_out_end        <= i_item.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_name_start  = r_out_start;
    assign o_name_length = r_out_len;
    assign o_name_valid  = r_out_name_valid;
    assign o_text_end    = r_out_end;

endmodule

[hw/rtl/scoped_identifier_scanner.sv]
`timescale 1ns / 1ps
// Top level of the scoped identifier scanner: ports, threshold register, wiring.
//
// Usage
//   s_axis carries the text one byte per beat in tdata, tlast on the final byte.
//   m_axis carries one beat per found name: tdata holds the byte offset (low
//   32 bits) and byte length (high 32 bits), tuser is 1 when a name is present,
//   tlast marks the beat caused by the final byte, which is always sent.
//   The cfg channel writes the 4-bit minimum first-run length; it is always
//   ready and should be written only while no text is in flight.
// Timing
//   One byte is taken every cycle unless the queue is full. The byte that
//   settles a result goes through a queue slot, then the result register; a
//   byte that starts a multi-byte letter is settled only by the bytes that
//   follow it. The front end classifies bytes, a two-entry queue feeds the
//   back-end state machine, and a result register sits at the output, so the sides stall independently.
// Reset and stall
//   Reset empties the queue, clears offsets and scan state and sets the
//   threshold to 4. While m_axis_tready is low the result register holds,
//   the queue fills, and s_axis_tready drops once the queue is full.
module scoped_identifier_scanner (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Text input
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] text_byte
    input  logic                          s_axis_tlast,   // text_last
    // Result output
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [2*ssc_pkg::OUT_BITS-1:0] m_axis_tdata,  // [31:0] name_start, [63:32] name_length
    output logic                          m_axis_tuser,   // name_valid
    output logic                          m_axis_tlast,   // text_end
    // Threshold write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ssc_pkg::RUN_BITS-1:0]  i_cfg_data      // min_run_chars
);

    logic [ssc_pkg::RUN_BITS-1:0] r_min_run;
    logic                         w_push;
    logic                         w_pop;
    ssc_pkg::t_item               w_push_item;
    ssc_pkg::t_item               w_head_item;
    ssc_pkg::t_q_status           w_q_status;
    logic [ssc_pkg::OUT_BITS-1:0] w_name_start;
    logic [ssc_pkg::OUT_BITS-1:0] w_name_length;

    // Threshold register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_run <= ssc_pkg::MIN_RUN_RESET;
        end else if (i_cfg_valid) begin
            r_min_run <= i_cfg_data;
        end
    end

    ssc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (s_axis_tvalid),
        .i_byte       (s_axis_tdata),
        .i_byte_last  (s_axis_tlast),
        .o_byte_ready (s_axis_tready),
        .i_q_full     (w_q_status.full),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    ssc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_item   (w_head_item),
        .o_status (w_q_status)
    );

    ssc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_min_run     (r_min_run),
        .i_item_valid  (!w_q_status.empty),
        .i_item        (w_head_item),
        .o_pop         (w_pop),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_name_start  (w_name_start),
        .o_name_length (w_name_length),
        .o_name_valid  (m_axis_tuser),
        .o_text_end    (m_axis_tlast)
    );

    assign m_axis_tdata = {w_name_length, w_name_start};

endmodule
